### rtl/core/conv3x3_single_channel_relu_macros.svh
// assertion macros shared by the conv3x3 block
// no dependencies; included by files that carry concurrent assertions
`ifndef CONV3X3_SINGLE_CHANNEL_RELU_MACROS_SVH
`define CONV3X3_SINGLE_CHANNEL_RELU_MACROS_SVH

// same-cycle implication, disabled in reset
`define C3R_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define C3R_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/c3r_pkg.sv
// shared types, codes and constants of the conv3x3 block
// no dependencies
package c3r_pkg;

  localparam int MAX_WIDTH_DEF   = 32;
  localparam int FILT_CNT_DEF    = 32;
  localparam int HEIGHT_LIMIT    = 64;
  localparam int TAPS            = 9;
  localparam int ACC_W           = 36;
  localparam int CFG_W           = 7;
  localparam int CFG_IDX_W       = 1;

  localparam logic [5:0] FRAME_WIDTH_RST  = 6'd28;
  localparam logic [6:0] FRAME_HEIGHT_RST = 7'd28;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // input command codes
  localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_LOAD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_SAMPLE      = 2'd2;
  localparam logic [1:0] CMD_RESERVED    = 2'd3;

  localparam logic [14:0] FEATURE_MAX = 15'h7fff;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic prep_dims;
    logic prep_norm;
    logic prep_read;
    logic row_step;
    logic tap_load;
    logic issue;
  } c3r_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic have_out;
    logic div_busy;
    logic adv;
    logic f_last;
    logic front_busy;
  } c3r_sts_t;

endpackage

### rtl/core/c3r_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on nothing; used by c3r_dp for pixel row and column
module c3r_div #(
  parameter int NUM_W = 12,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // shift in next numerator bit and try subtracting
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      if (fits) begin
        rem_r <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem_r <= DEN_W'(trial);
      end
      q_r <= {q_r[NUM_W-2:0], fits};
    end
  end

  assign busy = cnt_r != '0;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule

### rtl/core/c3r_dp.sv
// datapath: config, line buffers, window, stores and the filter MAC pipeline
// depends on c3r_pkg and c3r_div
module c3r_dp
  import c3r_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int FILT_CNT  = FILT_CNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [1:0]           in_command,
  input  logic [8:0]           in_index,
  input  logic signed [15:0]   in_value,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [4:0]           out_filter_index,
  output logic [14:0]          out_feature,
  output logic                 out_active,
  output logic                 out_last,
  input  c3r_cmd_t             cmd,
  output c3r_sts_t             sts
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int HW  = 7;
  localparam int CW  = $clog2(HEIGHT_LIMIT * MAX_WIDTH + MAX_WIDTH + 2);
  localparam int FIW = (FILT_CNT > 1) ? $clog2(FILT_CNT) : 1;

  // configuration registers
  logic [5:0] fw_r;
  logic [6:0] fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST;
      fh_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= cfg_data[5:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamped frame geometry
  logic [WW-1:0] wc_r;
  logic [HW-1:0] hc_r;
  logic [CW-1:0] npix_r, ramp_r, total_r;
  logic [WW-1:0] wc_nxt;
  logic [HW-1:0] hc_nxt;

  always_comb begin
    if (fw_r < 6'd3) begin
      wc_nxt = WW'(3);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      wc_nxt = WW'(MAX_WIDTH);
    end else begin
      wc_nxt = WW'(fw_r);
    end
    if (fh_r < 7'd3) begin
      hc_nxt = HW'(3);
    end else if (32'(fh_r) > HEIGHT_LIMIT) begin
      hc_nxt = HW'(HEIGHT_LIMIT);
    end else begin
      hc_nxt = fh_r;
    end
  end

  // position counters
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] cp_r;
  logic [CW-1:0] cnt_inc;
  logic signed [15:0] val_r, px_r;
  logic          have_out_r;
  logic [CW-1:0] p_r;

  assign cnt_inc = cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      cp_r       <= '0;
      have_out_r <= 1'b0;
    end else begin
      if (cmd.prep_norm) begin
        if (cnt_r >= npix_r + ramp_r) begin
          cnt_r <= '0;
          cp_r  <= '0;
        end else if (WW'(cp_r) >= wc_r) begin
          cp_r <= '0;
        end
      end
      if (cmd.prep_read) begin
        have_out_r <= cnt_r >= ramp_r;
      end
      if (cmd.row_step) begin
        if (cnt_inc >= total_r) begin
          cnt_r <= '0;
          cp_r  <= '0;
        end else begin
          cnt_r <= cnt_inc;
          if (WW'(cp_r) == wc_r - 1'b1) begin
            cp_r <= '0;
          end else begin
            cp_r <= cp_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r <= in_value;
    end
    if (cmd.prep_dims) begin
      wc_r   <= wc_nxt;
      hc_r   <= hc_nxt;
      npix_r <= CW'(32'(wc_nxt) * 32'(hc_nxt));
      ramp_r <= CW'(wc_nxt) + 1'b1;
    end
    if (cmd.prep_norm) begin
      total_r <= npix_r + ramp_r;
    end
    if (cmd.prep_read) begin
      px_r <= (cnt_r < npix_r) ? val_r : 16'sd0;
      p_r  <= cnt_r - ramp_r;
    end
  end

  // line buffers, cleared by a sweep after reset
  logic signed [15:0] row0 [MAX_WIDTH];
  logic signed [15:0] row1 [MAX_WIDTH];
  logic signed [15:0] row0_rd_r, row1_rd_r;
  logic [AW-1:0]      clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      row0[clr_addr_r] <= '0;
    end else if (cmd.row_step) begin
      row0[cp_r] <= row1_rd_r;
    end
    if (cmd.prep_read) begin
      row0_rd_r <= row0[cp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      row1[clr_addr_r] <= '0;
    end else if (cmd.row_step) begin
      row1[cp_r] <= px_r;
    end
    if (cmd.prep_read) begin
      row1_rd_r <= row1[cp_r];
    end
  end

  // 3x3 window shift
  logic signed [15:0] win_r [TAPS];
  logic signed [15:0] win_in [3];

  assign win_in[0] = row0_rd_r;
  assign win_in[1] = row1_rd_r;
  assign win_in[2] = px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.row_step) begin
      for (int fy = 0; fy < 3; fy++) begin
        win_r[fy*3]     <= win_r[fy*3 + 1];
        win_r[fy*3 + 1] <= win_r[fy*3 + 2];
        win_r[fy*3 + 2] <= win_in[fy];
      end
    end
  end

  // output pixel row and column
  logic          div_busy;
  logic [CW-1:0] quo;
  logic [WW-1:0] rem;

  c3r_div #(
    .NUM_W(CW),
    .DEN_W(WW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.row_step & have_out_r),
    .num  (p_r),
    .den  (wc_r),
    .busy (div_busy),
    .quo  (quo),
    .rem  (rem)
  );

  // edge masks and tap capture
  logic edge_top, edge_bot, edge_left, edge_right;
  logic signed [15:0] tap_r [TAPS];

  assign edge_top   = quo == '0;
  assign edge_bot   = ({1'b0, quo} + 1'b1) >= (CW+1)'(hc_r);
  assign edge_left  = rem == '0;
  assign edge_right = ({1'b0, rem} + 1'b1) >= {1'b0, wc_r};

  always_ff @(posedge clk) begin
    if (cmd.tap_load) begin
      for (int fy = 0; fy < 3; fy++) begin
        for (int fx = 0; fx < 3; fx++) begin
          if ((fy == 0 && edge_top) || (fy == 2 && edge_bot) ||
              (fx == 0 && edge_left) || (fx == 2 && edge_right)) begin
            tap_r[fy*3 + fx] <= '0;
          end else begin
            tap_r[fy*3 + fx] <= win_r[fy*3 + fx];
          end
        end
      end
    end
  end

  // store write decode
  logic [31:0]    idx32;
  logic [TAPS-1:0] w_we;
  logic [FIW-1:0] w_waddr;
  logic           b_we;

  assign idx32 = 32'(in_index);

  always_comb begin
    w_we    = '0;
    w_waddr = '0;
    for (int t = 0; t < TAPS; t++) begin
      if (idx32 >= 32'(t * FILT_CNT) && idx32 < 32'((t + 1) * FILT_CNT)) begin
        w_we[t] = cmd.accept && in_command == CMD_LOAD_WEIGHT;
        w_waddr = FIW'(idx32 - 32'(t * FILT_CNT));
      end
    end
    b_we = cmd.accept && in_command == CMD_LOAD_BIAS && idx32 < 32'(FILT_CNT);
  end

  // filter issue
  logic           adv, iss;
  logic [FIW-1:0] f_r;

  assign adv = !out_valid || out_ready;
  assign iss = cmd.issue && adv;

  always_ff @(posedge clk) begin
    if (cmd.tap_load) begin
      f_r <= '0;
    end else if (iss) begin
      f_r <= f_r + 1'b1;
    end
  end

  // weight banks, one per tap, and bias store
  logic signed [15:0] wrd_r [TAPS];
  logic signed [15:0] brd_r;
  logic signed [15:0] bias_mem [FILT_CNT];

  for (genvar g = 0; g < TAPS; g++) begin : g_wbank
    logic signed [15:0] mem [FILT_CNT];
    always_ff @(posedge clk) begin
      if (w_we[g]) begin
        mem[w_waddr] <= in_value;
      end
      if (iss) begin
        wrd_r[g] <= mem[f_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bias_mem[FIW'(in_index)] <= in_value;
    end
    if (iss) begin
      brd_r <= bias_mem[f_r];
    end
  end

  // MAC pipeline: products, two partial sums, round and saturate
  logic           a_vld_r, b_vld_r, c_vld_r;
  logic [FIW-1:0] a_f_r, b_f_r, c_f_r;
  logic           a_last_r, b_last_r, c_last_r;
  logic signed [31:0]      prod_r [TAPS];
  logic signed [15:0]      bb_r;
  logic signed [ACC_W-1:0] s1_r, s2_r, acc;
  logic [ACC_W-1:0]        rnd;
  logic [4:0]              ofi_r;
  logic [14:0]             feat_r;
  logic                    act_r, olast_r, oval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      oval_r  <= 1'b0;
    end else if (adv) begin
      a_vld_r <= cmd.issue;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      oval_r  <= c_vld_r;
    end
  end

  assign acc = s1_r + s2_r;
  assign rnd = ACC_W'(acc + ACC_W'(128));

  always_ff @(posedge clk) begin
    if (adv) begin
      a_f_r    <= f_r;
      a_last_r <= f_r == FIW'(FILT_CNT - 1);
      for (int i = 0; i < TAPS; i++) begin
        prod_r[i] <= tap_r[i] * wrd_r[i];
      end
      bb_r     <= brd_r;
      b_f_r    <= a_f_r;
      b_last_r <= a_last_r;
      s1_r <= (ACC_W'(bb_r) <<< 8) + ACC_W'(prod_r[0]) + ACC_W'(prod_r[1])
            + ACC_W'(prod_r[2]) + ACC_W'(prod_r[3]);
      s2_r <= ACC_W'(prod_r[4]) + ACC_W'(prod_r[5]) + ACC_W'(prod_r[6])
            + ACC_W'(prod_r[7]) + ACC_W'(prod_r[8]);
      c_f_r    <= b_f_r;
      c_last_r <= b_last_r;
      ofi_r    <= 5'(c_f_r);
      olast_r  <= c_last_r;
      act_r    <= acc > 0;
      if (acc <= 0) begin
        feat_r <= '0;
      end else if (rnd[ACC_W-1:8] > (ACC_W-8)'(FEATURE_MAX)) begin
        feat_r <= FEATURE_MAX;
      end else begin
        feat_r <= rnd[22:8];
      end
    end
  end

  assign out_valid        = oval_r;
  assign out_filter_index = ofi_r;
  assign out_feature      = feat_r;
  assign out_active       = act_r;
  assign out_last         = olast_r;

  // status back to the controller
  assign sts.clr_last   = clr_addr_r == AW'(MAX_WIDTH - 1);
  assign sts.have_out   = have_out_r;
  assign sts.div_busy   = div_busy;
  assign sts.adv        = adv;
  assign sts.f_last     = f_r == FIW'(FILT_CNT - 1);
  assign sts.front_busy = a_vld_r;

endmodule

### rtl/core/c3r_ctrl.sv
// controller state machine sequencing each word through the datapath
// depends on c3r_pkg
module c3r_ctrl
  import c3r_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  output c3r_cmd_t   cmd,
  input  c3r_sts_t   sts
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIMS = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_READ = 4'd4;
  localparam logic [3:0] S_STEP = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_TAP  = 4'd7;
  localparam logic [3:0] S_RUN  = 4'd8;
  localparam logic [3:0] S_WAIT = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: if (accept && in_command == CMD_SAMPLE) state_nxt = S_DIMS;
      S_DIMS: state_nxt = S_NORM;
      S_NORM: state_nxt = S_READ;
      S_READ: state_nxt = S_STEP;
      S_STEP: state_nxt = sts.have_out ? S_DIV : S_IDLE;
      S_DIV:  if (!sts.div_busy) state_nxt = S_TAP;
      S_TAP:  state_nxt = S_RUN;
      S_RUN:  if (sts.adv && sts.f_last) state_nxt = S_WAIT;
      S_WAIT: if (!sts.front_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.clr       = state_r == S_CLR;
    cmd.accept    = accept;
    cmd.prep_dims = state_r == S_DIMS;
    cmd.prep_norm = state_r == S_NORM;
    cmd.prep_read = state_r == S_READ;
    cmd.row_step  = state_r == S_STEP;
    cmd.tap_load  = state_r == S_TAP;
    cmd.issue     = state_r == S_RUN;
  end

endmodule

### rtl/core/conv3x3_single_channel_relu.sv
// top level of the 3x3 single-channel convolution with bias and relu
// depends on c3r_pkg, c3r_ctrl, c3r_dp and the macros header
//
//   port group   direction   handshake          contents
//   in_*         input       valid / ready      command, index, value
//   out_*        output      valid / ready      filter_index, feature, active, last
//   cfg_*        input       write enable       frame_width (0), frame_height (1)
//
// load words and unused commands are taken in the idle state and leave it unchanged
// a sample word passes the dims, norm, read and step states, plus (when it gives
// results) a bit-serial divide, a tap load and filter issue, one filter per cycle
// unless the output stalls, into the MAC pipeline, and then a wait state
// after reset a sweep clearing all MAX_WIDTH line buffer entries holds in_ready low
// a stalled output freezes the MAC pipeline; results are never dropped
`include "conv3x3_single_channel_relu_macros.svh"

module conv3x3_single_channel_relu
  import c3r_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int FILT_CNT  = FILT_CNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [8:0]           in_index,
  input  logic signed [15:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [4:0]           out_filter_index,
  output logic [14:0]          out_feature,
  output logic                 out_active,
  output logic                 out_last
);

  c3r_cmd_t cmd;
  c3r_sts_t sts;

  c3r_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_command),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  c3r_dp #(
    .MAX_WIDTH(MAX_WIDTH),
    .FILT_CNT (FILT_CNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_command      (in_command),
    .in_index        (in_index),
    .in_value        (in_value),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_filter_index(out_filter_index),
    .out_feature     (out_feature),
    .out_active      (out_active),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

  // a sample word blocks the next word
  `C3R_ASSERT_NEXT(a_sample_blocks, clk, rst_n, in_valid && in_ready && in_command == CMD_SAMPLE, !in_ready, "sample word did not block input")
  // taps are never overwritten while filters still read them
  `C3R_ASSERT_NOW(a_ready_front_idle, clk, rst_n, in_ready, !sts.front_busy, "input ready while weight reads in flight")
  // last flag sits on the final filter
  `C3R_ASSERT_NOW(a_last_index, clk, rst_n, out_valid && out_last, out_filter_index == 5'(FILT_CNT - 1), "last flag on wrong filter")

endmodule

### bench/conv3x3_checker.sv
// result checker for the 3x3 convolution with bias and relu: watches the ports,
// predicts every result word and compares it; depends on c3r_pkg
`timescale 1ns / 1ps

module conv3x3_checker
  import c3r_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic [8:0]           in_index,
  input  logic signed [15:0]   in_value,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [4:0]           out_filter_index,
  input  logic [14:0]          out_feature,
  input  logic                 out_active,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   pending
);

  localparam int NF = FILT_CNT_DEF;
  localparam int MW = MAX_WIDTH_DEF;

  typedef struct packed {
    logic [4:0]  filter_index;
    logic [14:0] feature;
    logic        active;
    logic        last;
  } feature_word_t;

  feature_word_t expected_features[$];

  // model state
  logic [5:0]         width_reg;
  logic [6:0]         height_reg;
  logic signed [15:0] line_buf [2][MW];
  logic signed [15:0] window [3][3];
  logic signed [15:0] weights [TAPS*NF];
  logic signed [15:0] biases [NF];
  int                 col_ptr;
  int                 pix_count;
  int                 errors;

  // conv step for one accepted word, queues the filter outputs it causes
  task automatic predict_conv(input logic [1:0] cmd, input logic [8:0] idx,
                              input logic signed [15:0] val);
    int                 w, h, npix, ramp, total, c, p, py, pxx;
    logic signed [15:0] pix;
    logic signed [15:0] tap [3][3];
    longint             acc, feat;
    feature_word_t      r;
    bit                 outside;
    case (cmd)
      CMD_LOAD_WEIGHT: if (idx < TAPS*NF) weights[idx] = val;
      CMD_LOAD_BIAS:   if (idx < NF) biases[idx] = val;
      CMD_SAMPLE: begin
        w = (width_reg < 3) ? 3 : (width_reg > MW) ? MW : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
        npix = w * h;
        ramp = w + 1;
        total = npix + ramp;
        if (pix_count >= total) begin
          pix_count = 0;
          col_ptr = 0;
        end
        if (col_ptr >= w) col_ptr = 0;
        c = pix_count;
        pix = (c < npix) ? val : 16'sd0;
        // shift the window and the line buffers
        for (int fy = 0; fy < 3; fy++) begin
          window[fy][0] = window[fy][1];
          window[fy][1] = window[fy][2];
          window[fy][2] = (fy < 2) ? line_buf[fy][col_ptr] : pix;
        end
        line_buf[0][col_ptr] = line_buf[1][col_ptr];
        line_buf[1][col_ptr] = pix;
        if (c >= ramp) begin
          p = c - ramp;
          py = p / w;
          pxx = p % w;
          // zero padding at the frame border
          for (int fy = 0; fy < 3; fy++) begin
            for (int fx = 0; fx < 3; fx++) begin
              outside = (fy == 0 && py == 0) || (fy == 2 && py + 1 >= h) ||
                        (fx == 0 && pxx == 0) || (fx == 2 && pxx + 1 >= w);
              tap[fy][fx] = outside ? 16'sd0 : window[fy][fx];
            end
          end
          for (int f = 0; f < NF; f++) begin
            acc = longint'(biases[f]) * 256;
            for (int fy = 0; fy < 3; fy++)
              for (int fx = 0; fx < 3; fx++)
                acc += longint'(tap[fy][fx]) * longint'(weights[fy*3*NF + fx*NF + f]);
            feat = 0;
            if (acc > 0) begin
              feat = (acc + 128) >>> 8;
              if (feat > 32767) feat = 32767;
            end
            r.filter_index = f[4:0];
            r.feature = feat[14:0];
            r.active = (acc > 0);
            r.last = (f == NF - 1);
            expected_features.push_back(r);
          end
        end
        if (col_ptr == w - 1) col_ptr = 0;
        else col_ptr++;
        pix_count++;
        if (pix_count >= total) begin
          pix_count = 0;
          col_ptr = 0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    feature_word_t exp_w;
    if (!rst_n) begin
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      for (int i = 0; i < MW; i++) begin
        line_buf[0][i] = '0;
        line_buf[1][i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i/3][i%3] = '0;
      for (int i = 0; i < TAPS*NF; i++) weights[i] = '0;
      for (int i = 0; i < NF; i++) biases[i] = '0;
      col_ptr = 0;
      pix_count = 0;
      errors = 0;
      expected_features.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data[5:0];
        else if (cfg_index == REG_FRAME_HEIGHT) height_reg = cfg_data[6:0];
      end
      if (in_valid && in_ready) predict_conv(in_command, in_index, in_value);
      // compare an accepted result word with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_features.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: fi=%0d feat=%0d act=%0b last=%0b",
                     out_filter_index, out_feature, out_active, out_last);
        end else begin
          exp_w = expected_features.pop_front();
          if (exp_w.filter_index !== out_filter_index || exp_w.feature !== out_feature ||
              exp_w.active !== out_active || exp_w.last !== out_last) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp fi=%0d feat=%0d act=%0b last=%0b, ",
                        "got fi=%0d feat=%0d act=%0b last=%0b"},
                       exp_w.filter_index, exp_w.feature, exp_w.active, exp_w.last,
                       out_filter_index, out_feature, out_active, out_last);
          end
        end
      end
    end
    fail_count <= errors;
    pending <= expected_features.size();
  end

endmodule

### bench/testbench.sv
// stimulus and verdict for the 3x3 convolution with bias and relu
// depends on c3r_pkg, conv3x3_single_channel_relu and conv3x3_checker
`timescale 1ns / 1ps

module testbench;
  import c3r_pkg::*;

  localparam int NF        = FILT_CNT_DEF;
  localparam int LIMIT     = 2000000;
  localparam int HOLD_LONG = 3000;

  // frame sizes and word counts of the random phases
  localparam int PH_W [8] = '{63, 3, 5, 1, 10, 32, 4, 0};
  localparam int PH_H [8] = '{3, 127, 4, 100, 7, 64, 5, 0};
  localparam int PH_N [8] = '{12, 14, 30, 12, 14, 10, 26, 14};
  localparam logic [15:0] PIX_DIR [9] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001,
                                          16'hffff, 16'h0100, 16'hff00, 16'h7fff,
                                          16'h8000};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_command;
  logic [8:0]           in_index;
  logic signed [15:0]   in_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [4:0]           out_filter_index;
  logic [14:0]          out_feature;
  logic                 out_active;
  logic                 out_last;
  int                   fail_count;
  int                   pending;
  int                   cycles = 0;
  bit                   tx_idle;
  bit                   rx_idle;
  bit                   hold_req;

  conv3x3_single_channel_relu u_top (.*);

  conv3x3_checker u_checker (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_LONG;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // send one input word, waits for its handshake
  task automatic send_word(input logic [1:0] cmd, input logic [8:0] idx,
                           input logic [15:0] val);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_index <= idx;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait for every expected word
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (64) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_value();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  // stimulus
  initial begin
    int          r;
    logic [15:0] v;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_command = CMD_SAMPLE;
    in_index = '0;
    in_value = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill both stores, extremes among them
    for (int i = 0; i < TAPS*NF; i++) begin
      v = (i % 11 == 0) ? 16'h7fff : (i % 11 == 1) ? 16'h8000 : rand_value();
      send_word(CMD_LOAD_WEIGHT, 9'(i), v);
    end
    for (int i = 0; i < NF; i++) begin
      v = (i == 0) ? 16'h7fff : (i == 1) ? 16'h8000 : rand_value();
      send_word(CMD_LOAD_BIAS, 9'(i), v);
    end
    drain();

    // smallest frame with extreme pixels, ignored words and nonzero flush values
    cfg_write(REG_FRAME_WIDTH, 7'd0);
    cfg_write(REG_FRAME_HEIGHT, 7'd0);
    send_word(CMD_LOAD_WEIGHT, 9'd511, 16'h7fff);
    send_word(CMD_LOAD_WEIGHT, 9'd288, 16'h8000);
    send_word(CMD_LOAD_BIAS, 9'd32, 16'h7fff);
    send_word(CMD_LOAD_BIAS, 9'd511, 16'h8000);
    send_word(CMD_RESERVED, 9'h1ff, 16'hffff);
    for (int i = 0; i < 9; i++) send_word(CMD_SAMPLE, 9'h1ff, PIX_DIR[i]);
    for (int i = 0; i < 4; i++) send_word(CMD_SAMPLE, '0, (i % 2) ? 16'h8000 : 16'h7fff);
    drain();

    // random phases over several frame sizes
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_FRAME_WIDTH, 7'(PH_W[ph]));
      cfg_write(REG_FRAME_HEIGHT, 7'(PH_H[ph]));
      tx_idle = (ph % 3 != 0);
      rx_idle = (ph % 4 != 1);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PH_N[ph]; n++) begin
        r = $urandom_range(0, 99);
        if (r < 75) send_word(CMD_SAMPLE, 9'($urandom), rand_value());
        else if (r < 83) send_word(CMD_LOAD_WEIGHT, 9'($urandom_range(0, 287)), rand_value());
        else if (r < 88) send_word(CMD_LOAD_BIAS, 9'($urandom_range(0, 31)), rand_value());
        else if (r < 93) send_word(CMD_LOAD_WEIGHT, 9'($urandom_range(288, 511)), rand_value());
        else if (r < 96) send_word(CMD_LOAD_BIAS, 9'($urandom_range(32, 511)), rand_value());
        else send_word(CMD_RESERVED, 9'($urandom), 16'($urandom));
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
